/* rtl/pf_pkg.sv */
// Shared types, operation codes and cell arithmetic for the Playfair digraph encipherer.
// Used by pf_ctrl, pf_datapath and playfair_digraph_encrypt; depends on nothing else.
package pf_pkg;

	localparam int SIDE    = 5;
	localparam int CELLS   = 25;
	localparam int LETTERS = 26;

	localparam logic [4:0] LETTER_Q = 5'd16;
	localparam logic [4:0] LETTER_X = 5'd23;
	localparam logic [4:0] LETTER_Z = 5'd25;

	localparam logic [2:0] OP_CLEAR_KEY  = 3'd0;
	localparam logic [2:0] OP_KEY_LETTER = 3'd1;
	localparam logic [2:0] OP_KEY_DONE   = 3'd2;
	localparam logic [2:0] OP_PLAIN      = 3'd3;
	localparam logic [2:0] OP_END        = 3'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [4:0] letter;
	} req_t;

	typedef struct packed {
		logic [4:0] cipher_letter;
		logic       last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOKUP,
		ST_EMIT1,
		ST_EMIT2
	} state_t;

	typedef struct packed {
		logic clear_key;
		logic place_key;
		logic fill_start;
		logic fill_step;
		logic start_plain;
		logic start_end;
		logic lookup;
		logic load_first;
		logic load_second;
	} cmd_t;

	typedef struct packed {
		logic pending_valid;
		logic fill_done;
		logic out_free;
	} status_t;

	// Row of a cell index below 25.
	function automatic logic [2:0] cell_row(input logic [4:0] p);
		logic [2:0] r;
		if (p >= 5'(4 * SIDE)) r = 3'd4;
		else if (p >= 5'(3 * SIDE)) r = 3'd3;
		else if (p >= 5'(2 * SIDE)) r = 3'd2;
		else if (p >= 5'(SIDE)) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	// Cell index from row and column, r*5+c.
	function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
		return {r, 2'b00} + 5'(r) + 5'(c);
	endfunction

	function automatic logic [2:0] cell_col(input logic [4:0] p);
		logic [4:0] d;
		d = p - cell_index(cell_row(p), 3'd0);
		return d[2:0];
	endfunction

	// Step to the next row or column, wrapping around the square.
	function automatic logic [2:0] step_wrap(input logic [2:0] v);
		return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
	endfunction

endpackage

/* rtl/playfair_digraph_encrypt.sv */
// Playfair digraph encipherer, top level: controller plus datapath.
// A pair's letter positions are registered at the edge accepting the transaction that
// completes it, the two key square cells next, then the first and the second cipher letter
// in turn in the output register, each waiting while that register is full and stalled.
// Key done runs the fill sweep over all 26 letters, one letter per cycle. Reset (arst_n
// low, asynchronous) clears bookkeeping, pending letter and the output valid flag.
module playfair_digraph_encrypt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pf_pkg::req_t   req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pf_pkg::rsp_t   rsp
);
	import pf_pkg::*;

	// The controller sequences each transaction; the datapath holds all storage.
	cmd_t    cmd;
	status_t status;

	// Requests are taken only while the controller is idle. A pair is worked out in
	// three steps: the positions of both letters are read from the position memory at
	// the accepting edge, the Playfair rule selects two cells and reads them from the
	// key square, and the two cipher letters then go out through the output register.
	pf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.operation (req.operation),
		.status    (status),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	// The output register lets the next request be accepted while the final cipher
	// letter of a pair still waits on rsp_stall.
	pf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.letter    (req.letter),
		.rsp_stall (rsp_stall),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

/* rtl/pf_ctrl.sv */
// Controller state machine for the Playfair digraph encipherer.
// Depends on pf_pkg; drives the command struct of pf_datapath.
module pf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [2:0]       operation,
	input  pf_pkg::status_t  status,
	output logic             req_stall,
	output pf_pkg::cmd_t     cmd
);
	import pf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					unique case (operation)
						OP_CLEAR_KEY:  cmd.clear_key = 1'b1;
						OP_KEY_LETTER: cmd.place_key = 1'b1;
						OP_KEY_DONE: begin
							cmd.fill_start = 1'b1;
							state_d        = ST_FILL;
						end
						OP_PLAIN: begin
							cmd.start_plain = 1'b1;
							if (status.pending_valid) state_d = ST_LOOKUP;
						end
						OP_END: begin
							cmd.start_end = 1'b1;
							if (status.pending_valid) state_d = ST_LOOKUP;
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.fill_done) state_d = ST_IDLE;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_EMIT1;
			end
			ST_EMIT1: begin
				if (status.out_free) begin
					cmd.load_first = 1'b1;
					state_d        = ST_EMIT2;
				end
			end
			ST_EMIT2: begin
				if (status.out_free) begin
					cmd.load_second = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/pf_datapath.sv */
// Datapath of the Playfair digraph encipherer: key square, letter positions,
// pending letter, fill sweep counter and output register. Depends on pf_pkg.
module pf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  pf_pkg::cmd_t     cmd,
	input  logic [4:0]       letter,
	input  logic             rsp_stall,
	output pf_pkg::status_t  status,
	output logic             rsp_valid,
	output pf_pkg::rsp_t     rsp
);
	import pf_pkg::*;

	logic [4:0] square_mem [0:CELLS-1];
	logic [4:0] pos_mem [0:LETTERS-1];

	logic [LETTERS-1:0] used_q;
	logic [4:0]         fill_count_q;
	logic               pending_valid_q;
	logic [4:0]         pending_letter_q;
	logic [4:0]         sweep_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic [4:0] pa_q, pb_q;
	logic       va_q, vb_q;
	logic [4:0] k1_q, k2_q;

	logic [4:0] place_ltr;
	logic       place_req, place_en, ltr_used;
	logic [4:0] addr_a, addr_b;
	logic       pair_start;
	logic [4:0] p1, p2, o1, o2;
	logic [2:0] r1, c1, r2, c2;

	function automatic logic pos_known(input logic [4:0] l, input logic [LETTERS-1:0] u);
		return (l < 5'(LETTERS)) && (l != LETTER_Q) && u[l];
	endfunction

	// Placing one letter, either from a key transaction or from the fill sweep.
	assign place_ltr = cmd.fill_step ? sweep_q : letter;
	assign place_req = cmd.place_key | cmd.fill_step;
	assign ltr_used  = (place_ltr < 5'(LETTERS)) ? used_q[place_ltr] : 1'b1;
	assign place_en  = place_req && !ltr_used && (fill_count_q < 5'(CELLS));

	// Second letter of the pair that this transaction starts.
	assign pair_start = (cmd.start_plain | cmd.start_end) & pending_valid_q;
	assign addr_a     = pending_letter_q;
	always_comb begin
		if (cmd.start_end) begin
			addr_b = (pending_letter_q == LETTER_Z) ? LETTER_X : LETTER_Z;
		end else begin
			addr_b = (letter == pending_letter_q) ? LETTER_X : letter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q           <= LETTERS'(1) << LETTER_Q;
			fill_count_q     <= '0;
			pending_valid_q  <= 1'b0;
			pending_letter_q <= '0;
			sweep_q          <= '0;
		end else begin
			if (cmd.clear_key) begin
				used_q           <= LETTERS'(1) << LETTER_Q;
				fill_count_q     <= '0;
				pending_valid_q  <= 1'b0;
				pending_letter_q <= '0;
			end else if (place_en) begin
				used_q[place_ltr] <= 1'b1;
				fill_count_q      <= fill_count_q + 5'd1;
			end
			if (cmd.fill_start) begin
				sweep_q <= '0;
			end else if (cmd.fill_step) begin
				sweep_q <= sweep_q + 5'd1;
			end
			if (cmd.start_plain) begin
				if (!pending_valid_q) begin
					pending_valid_q  <= 1'b1;
					pending_letter_q <= letter;
				end else if (letter != pending_letter_q) begin
					pending_valid_q  <= 1'b0;
					pending_letter_q <= '0;
				end
			end else if (cmd.start_end) begin
				pending_valid_q  <= 1'b0;
				pending_letter_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			square_mem[fill_count_q] <= place_ltr;
			pos_mem[place_ltr]       <= fill_count_q;
		end
		if (pair_start) begin
			pa_q <= pos_mem[addr_a];
			pb_q <= pos_mem[addr_b];
			va_q <= pos_known(addr_a, used_q);
			vb_q <= pos_known(addr_b, used_q);
		end
		if (cmd.lookup) begin
			k1_q <= square_mem[o1];
			k2_q <= square_mem[o2];
		end
	end

	// Playfair rules on the two registered cell positions.
	assign p1 = va_q ? pa_q : 5'd0;
	assign p2 = vb_q ? pb_q : 5'd0;
	assign r1 = cell_row(p1);
	assign c1 = cell_col(p1);
	assign r2 = cell_row(p2);
	assign c2 = cell_col(p2);

	always_comb begin
		priority if (r1 == r2) begin
			o1 = cell_index(r1, step_wrap(c1));
			o2 = cell_index(r2, step_wrap(c2));
		end else if (c1 == c2) begin
			o1 = cell_index(step_wrap(r1), c1);
			o2 = cell_index(step_wrap(r2), c2);
		end else begin
			o1 = cell_index(r2, c1);
			o2 = cell_index(r1, c2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_first || cmd.load_second) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			out_q <= '{cipher_letter: k1_q, last: 1'b0};
		end else if (cmd.load_second) begin
			out_q <= '{cipher_letter: k2_q, last: 1'b1};
		end
	end

	assign rsp_valid            = out_valid_q;
	assign rsp                  = out_q;
	assign status.pending_valid = pending_valid_q;
	assign status.fill_done     = (sweep_q == 5'(LETTERS - 1));
	assign status.out_free      = !out_valid_q || !rsp_stall;

endmodule

/* bench/pf_tb_pkg.sv */
// Expected-result bookkeeping for the Playfair digraph encipherer testbench.
// Depends on pf_pkg for the transaction types, operation codes and letter constants.
package pf_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import pf_pkg::*;

	class digraph_checker;
		logic [4:0]         square[CELLS];
		logic [4:0]         where[LETTERS];
		logic [LETTERS-1:0] placed;
		int unsigned        filled;
		bit                 held_valid;
		logic [4:0]         held_letter;
		rsp_t               cipher_due[$];
		int unsigned        errors;

		function new();
			foreach (square[i]) square[i] = '0;
			errors = 0;
			wipe_key();
		endfunction

		// The square cells themselves survive a key clear.
		function void wipe_key();
			foreach (where[i]) where[i] = '0;
			placed = '0;
			placed[LETTER_Q] = 1'b1;
			filled = 0;
			held_valid = 1'b0;
			held_letter = '0;
		endfunction

		function void add_to_square(logic [4:0] l);
			if (l >= LETTERS || filled >= CELLS) return;
			if (placed[l]) return;
			square[filled] = l;
			where[l] = 5'(filled);
			placed[l] = 1'b1;
			filled++;
		endfunction

		function int unsigned square_cell(logic [4:0] l);
			if (l >= LETTERS) return 0;
			return (where[l] < CELLS) ? int'(where[l]) : 0;
		endfunction

		function void push_digraph(logic [4:0] a, logic [4:0] b);
			int unsigned p1, p2, r1, c1, r2, c2, o1, o2;
			rsp_t e;
			p1 = square_cell(a);
			p2 = square_cell(b);
			r1 = p1 / SIDE;
			c1 = p1 % SIDE;
			r2 = p2 / SIDE;
			c2 = p2 % SIDE;
			if (r1 == r2) begin
				o1 = r1 * SIDE + (c1 + 1) % SIDE;
				o2 = r2 * SIDE + (c2 + 1) % SIDE;
			end else if (c1 == c2) begin
				o1 = ((r1 + 1) % SIDE) * SIDE + c1;
				o2 = ((r2 + 1) % SIDE) * SIDE + c2;
			end else begin
				o1 = r2 * SIDE + c1;
				o2 = r1 * SIDE + c2;
			end
			e.cipher_letter = square[o1];
			e.last = 1'b0;
			cipher_due = {cipher_due, e};
			e.cipher_letter = square[o2];
			e.last = 1'b1;
			cipher_due = {cipher_due, e};
		endfunction

		function void take_request(req_t r);
			case (r.operation)
				OP_CLEAR_KEY: wipe_key();
				OP_KEY_LETTER: add_to_square(r.letter);
				OP_KEY_DONE: begin
					for (int l = 0; l < LETTERS; l++) add_to_square(5'(l));
				end
				OP_PLAIN: begin
					if (!held_valid) begin
						held_valid = 1'b1;
						held_letter = r.letter;
					end else if (held_letter != r.letter) begin
						push_digraph(held_letter, r.letter);
						held_valid = 1'b0;
						held_letter = '0;
					end else begin
						// A doubled letter is padded with x and stays held.
						push_digraph(held_letter, LETTER_X);
					end
				end
				OP_END: begin
					if (held_valid) begin
						push_digraph(held_letter,
							(held_letter == LETTER_Z) ? LETTER_X : LETTER_Z);
						held_valid = 1'b0;
						held_letter = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_cipher(rsp_t got);
			rsp_t want;
			if (cipher_due.size() == 0) begin
				$error("cipher_letter %0d last %0d arrived with nothing expected",
					got.cipher_letter, got.last);
				errors++;
				return;
			end
			want = cipher_due.pop_front();
			if (got.cipher_letter !== want.cipher_letter) begin
				$error("cipher_letter: expected %0d, got %0d", want.cipher_letter,
					got.cipher_letter);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

endpackage

/* bench/playfair_digraph_encrypt_tb.sv */
// Self-checking testbench for playfair_digraph_encrypt: directed key and message cases,
// then randomized keys and messages with random idling on both channels.
// Depends on pf_pkg and pf_tb_pkg (the expected cipher letter bookkeeping).
module playfair_digraph_encrypt_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pf_pkg::*;
	import pf_tb_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 12;
	localparam int RANDOM_ITEMS    = 1800;
	localparam int DRAIN_CYCLES    = 40;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int LONG_HOLD_AFTER = 300;
	localparam int LONG_HOLD       = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// When set, neither side inserts idle cycles, so back-to-back traffic gets exercised.
	bit no_idle = 1'b0;
	int unsigned cycle_count = 0;

	digraph_checker sb = new();

	always #(CLK_PERIOD / 2) clk = ~clk;

	playfair_digraph_encrypt u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	function automatic int unsigned idle_draw();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	// Plaintext letters lean toward repeats, x and z so that doubled letters, the
	// doubled-x pair and the z-padding rule come up often. A few letters are out of range.
	function automatic logic [4:0] plain_pick(logic [4:0] prev);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20) return prev;
		if (r < 23) return 5'($urandom_range(26, 31));
		if (r < 27) return LETTER_X;
		if (r < 30) return LETTER_Z;
		return 5'($urandom_range(0, 25));
	endfunction

	// Offer one transaction and return at the edge where it is accepted. The valid is
	// lowered only across a drawn gap, so it is never lowered and raised in one step.
	task automatic offer(input logic [2:0] op, input logic [4:0] ltr);
		int unsigned gap;
		req_t item;
		item.operation = op;
		item.letter = ltr;
		gap = idle_draw();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		sb.take_request(item);
	endtask

	// Receiver: after each accepted result it stalls for a drawn number of cycles.
	// Once, it holds off for a long stretch while the sender keeps offering, so the
	// block backs up and must stall its own input.
	initial begin : receiver
		int unsigned hold;
		int unsigned taken;
		bit long_done;
		rsp_stall = 1'b0;
		hold = 0;
		taken = 0;
		long_done = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				sb.check_cipher(rsp);
				taken++;
				hold = idle_draw();
				if (!long_done && taken == LONG_HOLD_AFTER) begin
					hold = LONG_HOLD;
					long_done = 1'b1;
				end
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("playfair_digraph_encrypt_tb: errors");
		$finish;
	end

	initial begin : stimulus
		int unsigned counted;
		int unsigned pick;
		int unsigned n;
		logic [4:0] prev;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		counted = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The square cells hold no reset value, so the first thing done is
		// a complete key; from then on every cell has been written and any pair is legal.
		offer(OP_CLEAR_KEY, 5'd0);
		offer(OP_KEY_LETTER, 5'd15);             // p
		offer(OP_KEY_LETTER, 5'd11);             // l
		offer(OP_KEY_LETTER, 5'd0);              // a
		offer(OP_KEY_LETTER, 5'd24);             // y
		offer(OP_KEY_LETTER, 5'd5);              // f
		offer(OP_KEY_LETTER, 5'd0);              // a again, skipped as a repeat
		offer(OP_KEY_LETTER, LETTER_Q);          // q never enters the square
		offer(OP_KEY_LETTER, 5'd31);             // out of range, ignored
		offer(OP_KEY_DONE, 5'd31);
		offer(OP_END, 5'd0);                     // nothing held, so no result
		offer(3'd5, 5'd31);                      // undefined operation codes
		offer(3'd7, 5'd0);
		offer(OP_PLAIN, 5'd7);                   // h h: doubled, padded with x
		offer(OP_PLAIN, 5'd7);
		offer(OP_PLAIN, 5'd4);                   // held h pairs with e
		offer(OP_PLAIN, LETTER_X);               // x x shares one cell
		offer(OP_PLAIN, LETTER_X);
		offer(OP_END, 5'd0);                     // lone x padded with z
		offer(OP_PLAIN, LETTER_Z);
		offer(OP_END, 5'd0);                     // lone z padded with x
		offer(OP_PLAIN, 5'd31);                  // out-of-range letter and q both sit
		offer(OP_PLAIN, LETTER_Q);               // at the first cell
		offer(OP_KEY_LETTER, 5'd1);              // square full, ignored
		offer(OP_KEY_DONE, 5'd0);                // repeated key done, ignored

		// Random part: mostly fresh keys and whole messages, with some noise mixed in.
		while (counted < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				offer(OP_CLEAR_KEY, 5'($urandom_range(0, 31)));
				n = $urandom_range(0, 14);
				repeat (n) begin
					offer(OP_KEY_LETTER, ($urandom_range(0, 19) == 0) ?
						5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25)));
				end
				// Now and then the key is left partial, so unplaced letters use cell 0.
				if ($urandom_range(0, 9) != 0) offer(OP_KEY_DONE, 5'($urandom_range(0, 31)));
				counted += n + 2;
			end else if (pick < 88) begin
				n = $urandom_range(1, 16);
				prev = 5'($urandom_range(0, 25));
				repeat (n) begin
					prev = plain_pick(prev);
					offer(OP_PLAIN, prev);
				end
				// Sometimes the message is left open and the next one continues it.
				if ($urandom_range(0, 7) != 0) offer(OP_END, 5'($urandom_range(0, 31)));
				counted += n + 1;
			end else begin
				case ($urandom_range(0, 4))
					0: offer(3'($urandom_range(5, 7)), 5'($urandom_range(0, 31)));
					1: begin
						offer(OP_END, 5'($urandom_range(0, 31)));
						counted++;
					end
					2: begin
						offer(OP_KEY_LETTER, 5'($urandom_range(0, 31)));
						counted++;
					end
					3: begin
						offer(OP_KEY_DONE, 5'($urandom_range(0, 31)));
						counted++;
					end
					default: begin
						// A clear in mid-message drops the held letter; the alphabet
						// square follows.
						offer(OP_PLAIN, 5'($urandom_range(0, 25)));
						offer(OP_CLEAR_KEY, 5'($urandom_range(0, 31)));
						offer(OP_KEY_DONE, 5'($urandom_range(0, 31)));
						counted += 3;
					end
				endcase
			end
		end
		req_valid <= 1'b0;
		no_idle = 1'b0;

		while (sb.cipher_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("playfair_digraph_encrypt_tb: clean");
		end else begin
			$display("playfair_digraph_encrypt_tb: errors");
		end
		$finish;
	end

endmodule
